### rtl/core/small_matrix_add_sub_mul_det_core_macros.svh
// Assertion macros for the small matrix core checker.
`ifndef SMALL_MATRIX_ADD_SUB_MUL_DET_CORE_MACROS_SVH
`define SMALL_MATRIX_ADD_SUB_MUL_DET_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SMAD_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smad assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define SMAD_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smad assertion failed");

`endif

### rtl/core/smad_pkg.sv
// Shared types and constants of the small matrix core.
`timescale 1ns / 1ps

package smad_pkg;

    localparam int ELEM_W   = 16;
    localparam int VALUE_W  = 64;
    localparam int INDEX_W  = 2;
    localparam int DET_SIZE = 2;

    localparam logic [1:0] KIND_SUM  = 2'd0;
    localparam logic [1:0] KIND_DIFF = 2'd1;
    localparam logic [1:0] KIND_PROD = 2'd2;
    localparam logic [1:0] KIND_DET  = 2'd3;

    typedef struct packed {
        logic [1:0]               kind;
        logic [INDEX_W-1:0]       row;
        logic [INDEX_W-1:0]       col;
        logic signed [VALUE_W-1:0] value;
        logic                     last;
    } res_t;

endpackage

### rtl/core/smad_ifs.sv
// Element and result channel interfaces of the small matrix core.
`timescale 1ns / 1ps

interface smad_elem_if;
    import smad_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [ELEM_W-1:0] element;

    modport source (output valid, output element, input ready);
    modport sink (input valid, input element, output ready);
endinterface

interface smad_res_if;
    import smad_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [1:0]                kind;
    logic [INDEX_W-1:0]        row;
    logic [INDEX_W-1:0]        col;
    logic signed [VALUE_W-1:0] value;
    logic                      last;

    modport source (output valid, output kind, output row, output col, output value,
                    output last, input ready);
    modport sink (input valid, input kind, input row, input col, input value,
                  input last, output ready);
endinterface

### rtl/core/smad_front.sv
// Front end: accepts elements, tags each with its matrix, cell and end-of-load flag.
`timescale 1ns / 1ps

module smad_front #(
    parameter int MATRIX_SIZE  = 2,
    parameter int ELEMENT_BITS = 16,
    localparam int CELLS = MATRIX_SIZE * MATRIX_SIZE,
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1,
    localparam int QW    = ELEMENT_BITS + AW + 2
) (
    input  logic          clk,
    input  logic          rst_n,
    smad_elem_if.sink     elem,
    output logic          q_valid,
    input  logic          q_ready,
    output logic [QW-1:0] q_data
);
    import smad_pkg::*;

    localparam int LW = $clog2(2 * CELLS);

    logic [LW-1:0] cnt_reg;
    logic [LW-1:0] cnt_next;
    logic [LW-1:0] cnt_b;
    logic          accept;
    logic          is_b;
    logic          is_last;
    logic [AW-1:0] idx;

    assign elem.ready = q_ready;
    assign q_valid    = elem.valid;
    assign accept     = elem.valid && q_ready;

    assign is_b    = cnt_reg >= LW'(CELLS);
    assign is_last = cnt_reg == LW'(2 * CELLS - 1);
    assign cnt_b   = cnt_reg - LW'(CELLS);
    assign idx     = is_b ? cnt_b[AW-1:0] : cnt_reg[AW-1:0];
    assign q_data  = {is_last, is_b, idx, elem.element[ELEMENT_BITS-1:0]};

    always_comb
    begin
        cnt_next = cnt_reg;
        if (accept)
        begin
            cnt_next = is_last ? '0 : LW'(cnt_reg + 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

### rtl/core/smad_queue.sv
// Short item queue between the front and back ends.
`timescale 1ns / 1ps

module smad_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);
    import smad_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             push;
    logic             pop;

    assign in_ready  = count_reg != CW'(DEPTH);
    assign out_valid = count_reg != '0;
    assign out_data  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_reg + 1'b1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_reg + 1'b1);
        end
        if (push && !pop)
        begin
            count_next = CW'(count_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            count_next = CW'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### rtl/core/smad_back.sv
// Back end: stores both matrices and sequences the sum, difference, product and, for a 2x2 matrix, the determinant.
`timescale 1ns / 1ps

module smad_back #(
    parameter int MATRIX_SIZE  = 2,
    parameter int ELEMENT_BITS = 16,
    localparam int CELLS = MATRIX_SIZE * MATRIX_SIZE,
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1,
    localparam int QW    = ELEMENT_BITS + AW + 2
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    output logic          q_ready,
    input  logic [QW-1:0] q_data,
    smad_res_if.source    res
);
    import smad_pkg::*;

    localparam int EB       = ELEMENT_BITS;
    localparam int IW       = (MATRIX_SIZE > 1) ? $clog2(MATRIX_SIZE) : 1;
    localparam int RW       = 2 * EB + $clog2(MATRIX_SIZE) + 1;
    localparam int MW       = 2 * EB;
    localparam int PW       = 2 * RW;
    localparam int DW       = (2 * RW + 1 > VALUE_W + 1) ? 2 * RW + 1 : VALUE_W + 1;
    localparam bit WITH_DET = (MATRIX_SIZE == DET_SIZE);

    localparam logic [3:0] S_LOAD = 4'd0;
    localparam logic [3:0] S_RD   = 4'd1;
    localparam logic [3:0] S_EX   = 4'd2;
    localparam logic [3:0] S_ACC  = 4'd3;
    localparam logic [3:0] S_OUT  = 4'd4;
    localparam logic [3:0] S_DRD  = 4'd5;
    localparam logic [3:0] S_DMP  = 4'd6;
    localparam logic [3:0] S_DMQ  = 4'd7;
    localparam logic [3:0] S_DSUB = 4'd8;

    logic [3:0]                state_reg;
    logic [3:0]                state_next;
    logic [1:0]                kind_reg;
    logic [1:0]                kind_next;
    logic [IW-1:0]             row_reg;
    logic [IW-1:0]             row_next;
    logic [IW-1:0]             col_reg;
    logic [IW-1:0]             col_next;
    logic [IW-1:0]             c_reg;
    logic [IW-1:0]             c_next;
    logic signed [RW-1:0]      res_reg;
    logic signed [RW-1:0]      res_next;
    logic signed [VALUE_W-1:0] det_reg;
    logic signed [VALUE_W-1:0] det_next;
    res_t                      out_reg;
    res_t                      out_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;

    logic signed [EB-1:0]      mem_a [CELLS];
    logic signed [EB-1:0]      mem_b [CELLS];
    logic signed [RW-1:0]      mem_p [CELLS];
    logic signed [EB-1:0]      a_rd_reg;
    logic signed [EB-1:0]      b_rd_reg;
    logic signed [RW-1:0]      p0_rd_reg;
    logic signed [RW-1:0]      p1_rd_reg;
    logic signed [2*EB-1:0]    mul_reg;
    logic signed [2*RW-1:0]    dp_reg;
    logic signed [2*RW-1:0]    dq_reg;

    logic signed [EB-1:0]      q_elem;
    logic [AW-1:0]             q_idx;
    logic                      q_is_b;
    logic                      q_last;
    logic                      pop;
    logic                      is_prod;
    logic                      row_last;
    logic                      col_last;
    logic                      c_last;
    logic                      out_free;
    logic [AW-1:0]             cell_idx;
    logic [AW-1:0]             a_addr;
    logic [AW-1:0]             b_addr;
    logic [AW-1:0]             p0_addr;
    logic [AW-1:0]             p1_addr;
    logic signed [RW-1:0]      a_ext;
    logic signed [RW-1:0]      b_ext;
    logic signed [RW-1:0]      mul_ext;
    logic signed [DW-1:0]      dp_ext;
    logic signed [DW-1:0]      dq_ext;
    logic signed [DW-1:0]      diff;
    logic [DW-VALUE_W:0]       diff_hi;
    logic signed [VALUE_W-1:0] det_sat;

    assign q_elem  = q_data[EB-1:0];
    assign q_idx   = q_data[EB+AW-1:EB];
    assign q_is_b  = q_data[EB+AW];
    assign q_last  = q_data[EB+AW+1];
    assign q_ready = state_reg == S_LOAD;
    assign pop     = q_valid && q_ready;

    assign is_prod  = kind_reg == KIND_PROD;
    assign row_last = row_reg == IW'(MATRIX_SIZE - 1);
    assign col_last = col_reg == IW'(MATRIX_SIZE - 1);
    assign c_last   = c_reg == IW'(MATRIX_SIZE - 1);
    assign out_free = !out_valid_reg || res.ready;

    assign cell_idx = AW'(row_reg) * AW'(MATRIX_SIZE) + AW'(col_reg);
    assign a_addr   = is_prod ? AW'(row_reg) * AW'(MATRIX_SIZE) + AW'(c_reg) : cell_idx;
    assign b_addr   = is_prod ? AW'(c_reg) * AW'(MATRIX_SIZE) + AW'(col_reg) : cell_idx;
    assign p0_addr  = (state_reg == S_DRD) ? '0 : AW'(1);
    assign p1_addr  = (state_reg == S_DRD) ? AW'(CELLS - 1) : AW'(CELLS - 2);

    assign a_ext   = {{(RW - EB){a_rd_reg[EB-1]}}, a_rd_reg};
    assign b_ext   = {{(RW - EB){b_rd_reg[EB-1]}}, b_rd_reg};
    assign mul_ext = {{(RW - 2 * EB){mul_reg[2*EB-1]}}, mul_reg};
    assign dp_ext  = {{(DW - 2 * RW){dp_reg[2*RW-1]}}, dp_reg};
    assign dq_ext  = {{(DW - 2 * RW){dq_reg[2*RW-1]}}, dq_reg};
    assign diff    = dp_ext - dq_ext;
    assign diff_hi = diff[DW-1:VALUE_W-1];

    always_comb
    begin
        if ((&diff_hi) || !(|diff_hi))
        begin
            det_sat = diff[VALUE_W-1:0];
        end
        else if (diff[DW-1])
        begin
            det_sat = {1'b1, {(VALUE_W - 1){1'b0}}};
        end
        else
        begin
            det_sat = {1'b0, {(VALUE_W - 1){1'b1}}};
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        c_next         = c_reg;
        res_next       = res_reg;
        det_next       = det_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !res.ready;
        unique case (state_reg)
            S_LOAD:
            begin
                if (pop && q_last)
                begin
                    kind_next  = KIND_SUM;
                    row_next   = '0;
                    col_next   = '0;
                    c_next     = '0;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_EX;
            end
            S_EX:
            begin
                if (is_prod)
                begin
                    state_next = S_ACC;
                end
                else
                begin
                    res_next   = (kind_reg == KIND_SUM) ? a_ext + b_ext : a_ext - b_ext;
                    state_next = S_OUT;
                end
            end
            S_ACC:
            begin
                res_next = (c_reg == '0) ? mul_ext : res_reg + mul_ext;
                if (c_last)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    c_next     = IW'(c_reg + 1'b1);
                    state_next = S_RD;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next.kind  = kind_reg;
                    out_next.row   = (kind_reg == KIND_DET) ? '0 : INDEX_W'(row_reg);
                    out_next.col   = (kind_reg == KIND_DET) ? '0 : INDEX_W'(col_reg);
                    out_next.value = (kind_reg == KIND_DET) ? det_reg
                                   : {{(VALUE_W - RW){res_reg[RW-1]}}, res_reg};
                    out_next.last  = (kind_reg == KIND_DET)
                                   || (is_prod && !WITH_DET && row_last && col_last);
                    c_next         = '0;
                    if (kind_reg == KIND_DET)
                    begin
                        state_next = S_LOAD;
                    end
                    else if (row_last && col_last)
                    begin
                        row_next = '0;
                        col_next = '0;
                        if (is_prod)
                        begin
                            if (WITH_DET)
                            begin
                                kind_next  = KIND_DET;
                                state_next = S_DRD;
                            end
                            else
                            begin
                                state_next = S_LOAD;
                            end
                        end
                        else
                        begin
                            kind_next  = kind_reg + 2'd1;
                            state_next = S_RD;
                        end
                    end
                    else
                    begin
                        if (col_last)
                        begin
                            col_next = '0;
                            row_next = IW'(row_reg + 1'b1);
                        end
                        else
                        begin
                            col_next = IW'(col_reg + 1'b1);
                        end
                        state_next = S_RD;
                    end
                end
            end
            S_DRD:
            begin
                state_next = S_DMP;
            end
            S_DMP:
            begin
                state_next = S_DMQ;
            end
            S_DMQ:
            begin
                state_next = S_DSUB;
            end
            S_DSUB:
            begin
                det_next   = det_sat;
                state_next = S_OUT;
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pop && !q_is_b)
        begin
            mem_a[q_idx] <= q_elem;
        end
        a_rd_reg <= mem_a[a_addr];
    end

    always_ff @(posedge clk)
    begin
        if (pop && q_is_b)
        begin
            mem_b[q_idx] <= q_elem;
        end
        b_rd_reg <= mem_b[b_addr];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_ACC && c_last)
        begin
            mem_p[cell_idx] <= res_next;
        end
        p0_rd_reg <= mem_p[p0_addr];
        p1_rd_reg <= mem_p[p1_addr];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_EX)
        begin
            mul_reg <= MW'(a_rd_reg) * MW'(b_rd_reg);
        end
        if (state_reg == S_DMP)
        begin
            dp_reg <= PW'(p0_rd_reg) * PW'(p1_rd_reg);
        end
        if (state_reg == S_DMQ)
        begin
            dq_reg <= PW'(p0_rd_reg) * PW'(p1_rd_reg);
        end
        res_reg <= res_next;
        det_reg <= det_next;
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            kind_reg      <= KIND_SUM;
            row_reg       <= '0;
            col_reg       <= '0;
            c_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            c_reg         <= c_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign res.valid = out_valid_reg;
    assign res.kind  = out_reg.kind;
    assign res.row   = out_reg.row;
    assign res.col   = out_reg.col;
    assign res.value = out_reg.value;
    assign res.last  = out_reg.last;

endmodule

### rtl/core/small_matrix_add_sub_mul_det_core.sv
// Top level of the small matrix add, subtract, multiply and determinant core.
`timescale 1ns / 1ps

// Feed the elements of A and then B, row-major, one item per cycle on elem; only the
// low ELEMENT_BITS bits of each element count. A two-entry queue takes them while the
// back end is loading, so they go in at one per cycle until a burst starts. The last
// element of B starts a burst on res: all of A+B, then A-B, then A*B in row-major order,
// and for a 2x2 matrix the saturated determinant of the product, flagged by last. Each
// sum or difference goes through a matrix store read, the add and the output register;
// each product element accumulates MATRIX_SIZE terms in turn through one multiplier,
// and the determinant then multiplies two pairs of product cells and subtracts them.
// Elements sent during a burst wait in the queue and stall elem once it is full.
module small_matrix_add_sub_mul_det_core #(
    parameter int MATRIX_SIZE  = 2,
    parameter int ELEMENT_BITS = 16
) (
    input logic        clk,
    input logic        rst_n,
    smad_elem_if.sink  elem,
    smad_res_if.source res
);
    import smad_pkg::*;

    localparam int CELLS = MATRIX_SIZE * MATRIX_SIZE;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int QW    = ELEMENT_BITS + AW + 2;

    logic          fq_valid;
    logic          fq_ready;
    logic [QW-1:0] fq_data;
    logic          qb_valid;
    logic          qb_ready;
    logic [QW-1:0] qb_data;

    smad_front #(
        .MATRIX_SIZE  (MATRIX_SIZE),
        .ELEMENT_BITS (ELEMENT_BITS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .elem    (elem),
        .q_valid (fq_valid),
        .q_ready (fq_ready),
        .q_data  (fq_data)
    );

    smad_queue #(
        .WIDTH (QW),
        .DEPTH (2)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_data  (qb_data)
    );

    smad_back #(
        .MATRIX_SIZE  (MATRIX_SIZE),
        .ELEMENT_BITS (ELEMENT_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (qb_valid),
        .q_ready (qb_ready),
        .q_data  (qb_data),
        .res     (res)
    );

endmodule

### rtl/core/smad_checker.sv
// Port-level checker of the small matrix core and its bind to the top level.
`timescale 1ns / 1ps
`include "small_matrix_add_sub_mul_det_core_macros.svh"

module smad_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic [1:0]                        out_kind,
    input logic [smad_pkg::INDEX_W-1:0]      out_row,
    input logic [smad_pkg::INDEX_W-1:0]      out_col,
    input logic signed [smad_pkg::VALUE_W-1:0] out_value,
    input logic                              out_last
);
    import smad_pkg::*;

    `SMAD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(out_value) && $stable(out_last))
    `SMAD_ASSERT_IMP(a_det_shape, out_valid && out_kind == KIND_DET,
        out_last && out_row == '0 && out_col == '0)
    `SMAD_ASSERT_NEXT(a_burst_gap, out_valid && out_ready && out_last,
        !(out_valid && out_last))
    `SMAD_ASSERT_NEXT(a_kind_order, out_valid && out_ready && out_kind == KIND_DIFF,
        !(out_valid && out_kind == KIND_SUM))

endmodule

bind small_matrix_add_sub_mul_det_core smad_checker u_smad_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .out_kind  (res.kind),
    .out_row   (res.row),
    .out_col   (res.col),
    .out_value (res.value),
    .out_last  (res.last)
);

### dv/tb_small_matrix_add_sub_mul_det_core.sv
// Testbench for the small matrix core: element loads checked against a result predictor.
`timescale 1ns / 1ps

module tb_small_matrix_add_sub_mul_det_core;
    import smad_pkg::*;

    localparam int N           = 2;
    localparam int EB          = 16;
    localparam int CELLS       = N * N;
    localparam int DIRECTED    = 24;
    localparam int RANDOM_LOADS = 32;
    localparam int IDLE_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 100;
    localparam int MAX_REPORTS = 10;

    class matrix_result_board;
        longint signed a_cells[CELLS];
        longint signed b_cells[CELLS];
        int unsigned   loaded;
        res_t          expected_q[$];
        int unsigned   fail_count;
        int unsigned   report_count;

        function new();
            loaded = 0;
            fail_count = 0;
            report_count = 0;
        endfunction

        function void push_result(logic [1:0] kind, int r, int c, longint signed v,
                                  logic last);
            res_t item;
            item.kind  = kind;
            item.row   = r[INDEX_W-1:0];
            item.col   = c[INDEX_W-1:0];
            item.value = v;
            item.last  = last;
            expected_q.push_back(item);
        endfunction

        function void note_element(logic [ELEM_W-1:0] raw);
            logic signed [EB-1:0]  low;
            longint signed         v;
            longint signed         acc;
            longint signed         prod[CELLS];
            logic signed [127:0]   p;
            logic signed [127:0]   q;
            logic signed [127:0]   d;
            longint signed         det;
            low = raw[EB-1:0];
            v = low;
            if (loaded < CELLS)
                a_cells[loaded] = v;
            else
                b_cells[loaded - CELLS] = v;
            loaded++;
            if (loaded < 2 * CELLS)
                return;
            loaded = 0;
            for (int i = 0; i < CELLS; i++)
                push_result(KIND_SUM, i / N, i % N, a_cells[i] + b_cells[i], 1'b0);
            for (int i = 0; i < CELLS; i++)
                push_result(KIND_DIFF, i / N, i % N, a_cells[i] - b_cells[i], 1'b0);
            for (int i = 0; i < N; i++)
            begin
                for (int j = 0; j < N; j++)
                begin
                    acc = 0;
                    for (int c = 0; c < N; c++)
                        acc += a_cells[i * N + c] * b_cells[c * N + j];
                    prod[i * N + j] = acc;
                    push_result(KIND_PROD, i, j, acc,
                                (N != DET_SIZE) && (i == N - 1) && (j == N - 1));
                end
            end
            if (N == DET_SIZE)
            begin
                p = prod[0];
                p = p * prod[CELLS - 1];
                q = prod[1];
                q = q * prod[CELLS - 2];
                d = p - q;
                if (d[127:63] != {65{d[127]}})
                    det = d[127] ? {1'b1, {63{1'b0}}} : {1'b0, {63{1'b1}}};
                else
                    det = d[63:0];
                push_result(KIND_DET, 0, 0, det, 1'b1);
            end
        endfunction

        function void check_result(res_t got);
            res_t want;
            if (expected_q.size() == 0)
            begin
                fail_count++;
                if (report_count < MAX_REPORTS)
                begin
                    report_count++;
                    $display("unexpected result: kind %0d row %0d col %0d value %0d last %0d",
                             got.kind, got.row, got.col, got.value, got.last);
                end
                return;
            end
            want = expected_q.pop_front();
            if (got.kind !== want.kind || got.row !== want.row || got.col !== want.col ||
                got.value !== want.value || got.last !== want.last)
            begin
                fail_count++;
                if (report_count < MAX_REPORTS)
                begin
                    report_count++;
                    $display("mismatch: expected kind %0d row %0d col %0d value %0d last %0d",
                             want.kind, want.row, want.col, want.value, want.last);
                    $display("          actual   kind %0d row %0d col %0d value %0d last %0d",
                             got.kind, got.row, got.col, got.value, got.last);
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    smad_elem_if elem_if();
    smad_res_if  res_if();

    small_matrix_add_sub_mul_det_core #(
        .MATRIX_SIZE  (N),
        .ELEMENT_BITS (EB)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .elem  (elem_if),
        .res   (res_if)
    );

    matrix_result_board board;
    bit          send_steady;
    bit          drain_steady;
    int          stall_left;
    int unsigned idle_cycles = 0;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    function automatic logic [ELEM_W-1:0] pick_element();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2)
        begin
            case ($urandom_range(0, 3))
                0: return 16'h8000;
                1: return 16'h7fff;
                2: return 16'h0000;
                default: return 16'hffff;
            endcase
        end
        else if (r < 4)
            return ELEM_W'($urandom_range(0, 15) - 8);
        else
            return ELEM_W'($urandom);
    endfunction

    task automatic send_element(input logic [ELEM_W-1:0] e);
        int gap;
        gap = send_steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            elem_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        elem_if.valid   <= 1'b1;
        elem_if.element <= e;
        @(posedge clk);
        while (!elem_if.ready)
            @(posedge clk);
        board.note_element(e);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_if.ready <= 1'b0;
            stall_left = 0;
        end
        else if (stall_left > 0)
        begin
            res_if.ready <= 1'b0;
            stall_left--;
        end
        else if (drain_steady)
            res_if.ready <= 1'b1;
        else
        begin
            stall_left = pick_gap();
            res_if.ready <= (stall_left == 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_if.valid && res_if.ready)
            board.check_result({res_if.kind, res_if.row, res_if.col, res_if.value,
                                res_if.last});
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((elem_if.valid && elem_if.ready) || (res_if.valid && res_if.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin
        logic [ELEM_W-1:0] directed_items[DIRECTED];
        board = new();
        directed_items = '{
            16'h8000, 16'h8000, 16'h8000, 16'h8000,
            16'h8000, 16'h7fff, 16'h7fff, 16'h8000,
            16'h8000, 16'h8000, 16'h7fff, 16'h8000,
            16'h8000, 16'h8000, 16'h7fff, 16'h8000,
            16'h0000, 16'h0001, 16'hffff, 16'h5555,
            16'haaaa, 16'h7fff, 16'h0000, 16'hfffe
        };
        rst_n = 1'b0;
        elem_if.valid = 1'b0;
        elem_if.element = '0;
        send_steady = 1'b0;
        drain_steady = 1'b1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED; i++)
        begin
            if (i % (2 * CELLS) == 0)
            begin
                send_steady = (i == 0);
                drain_steady = (i == 0);
            end
            send_element(directed_items[i]);
        end

        for (int n = 0; n < RANDOM_LOADS; n++)
        begin
            send_steady = ($urandom_range(0, 3) == 0);
            drain_steady = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < 2 * CELLS; k++)
                send_element(pick_element());
        end
        elem_if.valid <= 1'b0;

        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
